/* hdl/nmea_pkg.sv */
// Package for the NMEA sentence framer and checksum core.
// Holds character codes, outcome codes, the per-sentence state type and the hex
// nibble decoder. It depends on nothing else.
package nmea_pkg;

  localparam int MAX_LEN_DEFAULT = 128;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam int         MIN_LEN   = 5;
  localparam logic [1:0] AFTER_SAT = 2'd3;
  localparam logic [1:0] AFTER_TWO = 2'd2;

  localparam int LEN_OUT_W = 7;
  localparam int OUT_DATA_W = 128;

  localparam logic [1:0] OUTCOME_VALID    = 2'd0;
  localparam logic [1:0] OUTCOME_BAD      = 2'd1;
  localparam logic [1:0] OUTCOME_OVERFLOW = 2'd2;

  // Everything about an open sentence except its length, whose width
  // follows the buffer limit.
  typedef struct packed {
    logic [7:0] running_xor;
    logic       star_seen;
    logic [1:0] after_star_count;
    logic [7:0] hex_digits;
    logic       hex_all_valid;
  } sent_state_t;

  localparam sent_state_t SENT_STATE_RESET = '{
    running_xor:      8'd0,
    star_seen:        1'b0,
    after_star_count: 2'd0,
    hex_digits:       8'd0,
    hex_all_valid:    1'b1
  };

  // One finished sentence, without the running totals.
  typedef struct packed {
    logic [1:0]           outcome;
    logic [LEN_OUT_W-1:0] sentence_length;
    logic [7:0]           computed_checksum;
    logic [7:0]           received_checksum;
  } sent_result_t;

  // Returns {valid, value}; a non-hex character gives valid low and value 0.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

endpackage

/* hdl/nmea_step.sv */
// Combinational per-byte update of the NMEA sentence state.
// Decides the next state and whether this byte closes a sentence.
// Depends on nmea_pkg.
module nmea_step #(
  parameter int MAX_LEN = nmea_pkg::MAX_LEN_DEFAULT,
  parameter int LEN_W   = $clog2(MAX_LEN)
) (
  input  logic [7:0]               rx_byte,
  input  logic [LEN_W-1:0]         length,
  input  nmea_pkg::sent_state_t    st,
  output logic [LEN_W-1:0]         length_next,
  output nmea_pkg::sent_state_t    st_next,
  output logic                     emit,
  output nmea_pkg::sent_result_t   result
);

  localparam int EXT_W = (LEN_W > nmea_pkg::LEN_OUT_W) ? LEN_W : nmea_pkg::LEN_OUT_W;
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LEN - 1);
  localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(nmea_pkg::MIN_LEN);
  localparam logic [EXT_W-1:0] LEN_SAT   = EXT_W'((1 << nmea_pkg::LEN_OUT_W) - 1);

  logic                          is_open;
  logic                          ok;
  logic [EXT_W-1:0]              len_ext;
  logic [nmea_pkg::LEN_OUT_W-1:0] len_sat;
  logic [4:0]                    nib;

  assign is_open = (length != '0);
  assign len_ext = EXT_W'(length);
  assign len_sat = (len_ext > LEN_SAT) ? LEN_SAT[nmea_pkg::LEN_OUT_W-1:0]
                                       : len_ext[nmea_pkg::LEN_OUT_W-1:0];
  assign nib = nmea_pkg::hex_nibble(rx_byte);

  // Short sentences are still closed and reported, just as bad ones.
  assign ok = (length >= LEN_MIN) && st.star_seen &&
              (st.after_star_count == nmea_pkg::AFTER_TWO) &&
              st.hex_all_valid && (st.hex_digits == st.running_xor);

  always_comb begin
    length_next = length;
    st_next     = st;
    emit        = 1'b0;
    result.outcome           = nmea_pkg::OUTCOME_VALID;
    result.sentence_length   = len_sat;
    result.computed_checksum = st.running_xor;
    result.received_checksum = st.hex_digits;
    priority if (rx_byte == nmea_pkg::CH_DOLLAR) begin
      length_next = LEN_W'(1);
      st_next     = nmea_pkg::SENT_STATE_RESET;
    end else if (rx_byte == nmea_pkg::CH_CR || rx_byte == nmea_pkg::CH_LF) begin
      if (is_open) begin
        emit           = 1'b1;
        result.outcome = ok ? nmea_pkg::OUTCOME_VALID : nmea_pkg::OUTCOME_BAD;
        length_next    = '0;
      end
    end else if (is_open) begin
      if (length >= LEN_LIMIT) begin
        emit                     = 1'b1;
        result.outcome           = nmea_pkg::OUTCOME_OVERFLOW;
        result.computed_checksum = 8'd0;
        result.received_checksum = 8'd0;
        length_next              = '0;
      end else begin
        length_next = LEN_W'(length + 1'b1);
        if (!st.star_seen) begin
          if (rx_byte == nmea_pkg::CH_STAR) begin
            st_next.star_seen = 1'b1;
          end else begin
            st_next.running_xor = st.running_xor ^ rx_byte;
          end
        end else begin
          if (st.after_star_count < nmea_pkg::AFTER_TWO) begin
            if (!nib[4]) begin
              st_next.hex_all_valid = 1'b0;
            end
            st_next.hex_digits = {st.hex_digits[3:0], nib[3:0]};
          end
          if (st.after_star_count < nmea_pkg::AFTER_SAT) begin
            st_next.after_star_count = 2'(st.after_star_count + 1'b1);
          end
        end
      end
    end else begin
      // Bytes outside a sentence are ignored.
    end
  end

endmodule

/* hdl/nmea_sentence_framer_checksum_core.sv */
// Top level of the NMEA 0183 sentence framer and checksum checker.
// Input byte register, the per-byte update in nmea_step, and a result register.
// Depends on nmea_pkg and nmea_step.
//
//  Channel   Direction  Word                               Per word
//  s_axis    in         tdata[7:0] rx_byte                 one received byte
//  m_axis    out        tdata[127:0] outcome..totals       one closed or dropped sentence
//
// One byte per clock is sustained while m_axis takes each result. A byte sits
// in the input register and its result, if any, is loaded into the result
// register when that byte moves on.
// The whole per-byte update is a short compare and XOR path; the 32-bit total
// increments are the longest logic between registers.
// Reset (rst, synchronous) closes any open sentence, clears the totals and
// empties both registers.
// A stall on m_axis holds the result; the input register still takes a byte
// as long as the byte it holds can move on in the same cycle.
module nmea_sentence_framer_checksum_core #(
  parameter int MAX_LEN = nmea_pkg::MAX_LEN_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [7:0] rx_byte
  input  logic [7:0]   s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [1:0] outcome, [8:2] sentence_length, [16:9] computed_checksum,
  // [24:17] received_checksum, [56:25] good_total, [88:57] bad_checksum_total,
  // [120:89] overflow_total, [127:121] zero
  output logic [nmea_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int LEN_W = $clog2(MAX_LEN);
  localparam int PAY_W = 2 + nmea_pkg::LEN_OUT_W + 8 + 8 + 3 * 32;

  // Input register.
  logic       in_valid;
  logic [7:0] in_byte;

  // Sentence state.
  logic [LEN_W-1:0]      length;
  logic [LEN_W-1:0]      length_next;
  nmea_pkg::sent_state_t st;
  nmea_pkg::sent_state_t st_next;

  // Running totals.
  logic [31:0] good_counter;
  logic [31:0] bad_counter;
  logic [31:0] overflow_counter;
  logic [31:0] good_counter_next;
  logic [31:0] bad_counter_next;
  logic [31:0] overflow_counter_next;

  // Result register.
  logic                   out_valid;
  nmea_pkg::sent_result_t out_res;
  logic [31:0]            out_good;
  logic [31:0]            out_bad;
  logic [31:0]            out_overflow;

  logic                   emit;
  nmea_pkg::sent_result_t res;
  logic                   advance;

  // The held byte moves on whenever the result register is free or drains
  // in the same cycle; a byte without a result needs no room at all.
  assign advance       = in_valid && (!out_valid || m_axis_tready || !emit);
  assign s_axis_tready = !in_valid || advance;

  nmea_step #(
    .MAX_LEN (MAX_LEN),
    .LEN_W   (LEN_W)
  ) u_step (
    .rx_byte     (in_byte),
    .length      (length),
    .st          (st),
    .length_next (length_next),
    .st_next     (st_next),
    .emit        (emit),
    .result      (res)
  );

  always_comb begin
    good_counter_next     = good_counter;
    bad_counter_next      = bad_counter;
    overflow_counter_next = overflow_counter;
    if (emit) begin
      unique case (res.outcome)
        nmea_pkg::OUTCOME_VALID:    good_counter_next     = good_counter + 32'd1;
        nmea_pkg::OUTCOME_BAD:      bad_counter_next      = bad_counter + 32'd1;
        nmea_pkg::OUTCOME_OVERFLOW: overflow_counter_next = overflow_counter + 32'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length           <= '0;
      st               <= nmea_pkg::SENT_STATE_RESET;
      good_counter     <= 32'd0;
      bad_counter      <= 32'd0;
      overflow_counter <= 32'd0;
    end else if (advance) begin
      length           <= length_next;
      st               <= st_next;
      good_counter     <= good_counter_next;
      bad_counter      <= bad_counter_next;
      overflow_counter <= overflow_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (advance && emit) begin
      out_res      <= res;
      out_good     <= good_counter_next;
      out_bad      <= bad_counter_next;
      out_overflow <= overflow_counter_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {
    (nmea_pkg::OUT_DATA_W - PAY_W)'(0),
    out_overflow, out_bad, out_good,
    out_res.received_checksum, out_res.computed_checksum,
    out_res.sentence_length, out_res.outcome
  };

  // The length count never passes the buffer limit.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    length <= LEN_W'(MAX_LEN - 1))
    else $error("sentence length beyond limit");

  // A byte that closes a sentence leaves none open.
  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    advance && emit |=> length == '0)
    else $error("sentence still open after close");

  // A closing byte always lands in the result register.
  a_emit_shown: assert property (@(posedge clk) disable iff (rst)
    advance && emit |=> out_valid && out_res == $past(res))
    else $error("result not registered");

  // Dropped sentences report no checksums.
  a_overflow_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.outcome == nmea_pkg::OUTCOME_OVERFLOW |->
      out_res.computed_checksum == 8'd0 && out_res.received_checksum == 8'd0)
    else $error("overflow result carries checksums");

  // Totals only move when a result is produced.
  a_totals_quiet: assert property (@(posedge clk) disable iff (rst)
    !(advance && emit) |=> $stable(good_counter) && $stable(bad_counter) &&
      $stable(overflow_counter))
    else $error("totals changed without a result");

endmodule
